### rtl/core/bta_pkg.sv
`timescale 1ns / 1ps
package bta_pkg;

   localparam int ARENA_BYTES    = 4096;
   localparam int CHUNK_OVERHEAD = 33;
   localparam int DATA_OFFSET    = 25;
   localparam int MIN_ARENA      = 2 * CHUNK_OVERHEAD;

   localparam int ADDR_W = $clog2(ARENA_BYTES);
   localparam int LINK_W = ADDR_W + 1;
   localparam int PTR_W  = ADDR_W + 2;
   localparam int REQ_W  = 16;
   localparam int STAT_W = 2;

   // link value that points at no chunk
   localparam logic [LINK_W-1:0] NIL = LINK_W'(ARENA_BYTES);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

   typedef struct packed {
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] size;
      logic              is_free;
   } hdr_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      hdr_type          data;
   } hdr_wr_type;

   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [ADDR_W-1:0] data;
   } foot_wr_type;

endpackage

### rtl/core/bta_if.sv
`timescale 1ns / 1ps
interface bta_req_if import bta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [REQ_W-1:0]  req_size;
   logic              ptr_valid;
   logic [ADDR_W-1:0] data_offset;

   modport source (output valid, cmd, req_size, ptr_valid, data_offset, input ready);
   modport sink (input valid, cmd, req_size, ptr_valid, data_offset, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ADDR_W-1:0] result_offset;

   modport source (output valid, status, result_offset, input ready);
   modport sink (input valid, status, result_offset, output ready);
endinterface

interface bta_csr_if import bta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LINK_W-1:0] arena_size;

   modport source (output valid, arena_size, input ready);
   modport sink (input valid, arena_size, output ready);
endinterface

### rtl/core/boundary_tag_first_fit_allocator.sv
`timescale 1ns / 1ps
// null or outside frees go straight to the done state; an allocate reads one header
//   per free-list chunk visited, then splits or claims the fit, or reports that nothing fits
// throughput: one item at a time; a finished item waits in the done state while the
//   previous result is still held by the result side
// reset: synchronous, active high; the arena is rebuilt in S_INIT0 and S_INIT1 after reset
//   and after every arena_size write, with no clearing pass over the memories
module boundary_tag_first_fit_allocator import bta_pkg::*; (
   input logic     clock,
   input logic     reset,
   bta_req_if.sink   req_ch,
   bta_rsp_if.source rsp_ch,
   bta_csr_if.sink   csr_ch
);

   typedef enum logic [4:0] {
      S_INIT0, S_INIT1, S_IDLE,
      S_A_CHK, S_A_EVAL, S_A_POST, S_A_LO, S_A_HI, S_A_CLR,
      S_F_RD, S_F_H, S_F_L, S_F_LEV, S_F_R, S_F_REV, S_F_MRG,
      S_E_P, S_E_N, S_E_C,
      S_I_RD, S_I_GET, S_I_C1, S_I_PP, S_I_W, S_I_C2,
      S_DONE
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic              phase_ff, phase_in;
   logic [LINK_W-1:0] arena_ff, arena_in, head_ff, head_in, tail_ff, tail_in;
   logic [LINK_W-1:0] steps_ff, steps_in, h_size_ff, h_size_in, rest_ff, rest_in;
   logic [LINK_W-1:0] e_prev_ff, e_prev_in, e_next_ff, e_next_in, pp_ff, pp_in;
   logic [PTR_W-1:0]  cur_ff, cur_in, e_c_ff, e_c_in, ins_w_ff, ins_w_in;
   logic [PTR_W-1:0]  ins_c_ff, ins_c_in, lt_ff, lt_in, rt_ff, rt_in;
   logic [PTR_W-1:0]  right_ff, right_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in, rsp_stat_ff, rsp_stat_in;
   logic [ADDR_W-1:0] res_off_ff, res_off_in, rsp_off_ff, rsp_off_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PTR_W-1:0]  hdr_rd_addr;
   hdr_type           hdr_rd_data;
   hdr_wr_type        hdr_wr;
   logic [ADDR_W-1:0] foot_rd_addr;
   logic [ADDR_W-1:0] foot_rd_data;
   foot_wr_type       foot_wr;

   // read-modify-write step descriptor
   logic              rmw_state;
   logic [PTR_W-1:0]  rmw_addr;
   hdr_type           rmw_data;
   state_type         rmw_next;
   logic              rmw_done;

   logic              req_acc, csr_acc;
   logic [LINK_W-1:0] csr_clamped, sent;
   logic [16:0]       need, rest_w;
   logic [PTR_W-1:0]  got, sum_w, fsz;
   logic [ADDR_W:0]   off_rel;

   bta_store u_store (
      .clock        (clock),
      .hdr_rd_addr  (hdr_rd_addr),
      .hdr_rd_data  (hdr_rd_data),
      .hdr_wr       (hdr_wr),
      .foot_rd_addr (foot_rd_addr),
      .foot_rd_data (foot_rd_data),
      .foot_wr      (foot_wr)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !csr_ch.valid;
   assign csr_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_acc      = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_stat_ff;
   assign rsp_ch.result_offset = rsp_off_ff;

   // sentinel offset and helper sums
   assign sent    = arena_ff - LINK_W'(CHUNK_OVERHEAD);
   assign need    = 17'(req_ff) + 17'(CHUNK_OVERHEAD);
   assign rest_w  = 17'(h_size_ff) - need;
   assign got     = cur_ff + PTR_W'(rest_ff);
   assign sum_w   = cur_ff + PTR_W'(hdr_rd_data.size);
   assign fsz     = rt_ff - lt_ff;
   assign off_rel = {1'b0, req_ch.data_offset} - (ADDR_W+1)'(DATA_OFFSET);

   always_comb begin
      if (csr_ch.arena_size < LINK_W'(MIN_ARENA)) begin
         csr_clamped = LINK_W'(MIN_ARENA);
      end else if (csr_ch.arena_size > LINK_W'(ARENA_BYTES)) begin
         csr_clamped = LINK_W'(ARENA_BYTES);
      end else begin
         csr_clamped = csr_ch.arena_size;
      end
   end

   // header field updates used by list unlink, relink and the in-place allocate claim
   always_comb begin
      rmw_state = 1'b1;
      rmw_addr  = '0;
      rmw_data  = hdr_rd_data;
      rmw_next  = S_IDLE;
      case (state_ff)
         S_A_CLR: begin
            rmw_addr = cur_ff;   rmw_data.is_free = 1'b0; rmw_next = S_DONE;
         end
         S_E_P: begin
            rmw_addr = PTR_W'(e_prev_ff); rmw_data.next = e_next_ff; rmw_next = S_E_N;
         end
         S_E_N: begin
            rmw_addr = PTR_W'(e_next_ff); rmw_data.prev = e_prev_ff; rmw_next = S_E_C;
         end
         S_E_C: begin
            rmw_addr = e_c_ff;
            rmw_data.prev = NIL;
            rmw_data.next = NIL;
            rmw_next = ret_ff;
         end
         S_I_C1: begin
            rmw_addr = ins_c_ff; rmw_data.prev = pp_ff; rmw_next = S_I_PP;
         end
         S_I_PP: begin
            rmw_addr = PTR_W'(pp_ff); rmw_data.next = LINK_W'(ins_c_ff); rmw_next = S_I_W;
         end
         S_I_W: begin
            rmw_addr = ins_w_ff; rmw_data.prev = LINK_W'(ins_c_ff); rmw_next = S_I_C2;
         end
         S_I_C2: begin
            rmw_addr = ins_c_ff; rmw_data.next = LINK_W'(ins_w_ff); rmw_next = ret_ff;
         end
         default: rmw_state = 1'b0;
      endcase
   end

   // a step finishes after its write, or at once when the entry lies outside the arena
   assign rmw_done = rmw_state && (phase_ff || rmw_addr >= PTR_W'(ARENA_BYTES));

   always_comb begin
      state_in    = state_ff;   ret_in    = ret_ff;    phase_in  = phase_ff;
      arena_in    = arena_ff;   head_in   = head_ff;   tail_in   = tail_ff;
      steps_in    = steps_ff;   h_size_in = h_size_ff; rest_in   = rest_ff;
      e_prev_in   = e_prev_ff;  e_next_in = e_next_ff; pp_in     = pp_ff;
      cur_in      = cur_ff;     e_c_in    = e_c_ff;    ins_w_in  = ins_w_ff;
      ins_c_in    = ins_c_ff;   lt_in     = lt_ff;     rt_in     = rt_ff;
      right_in    = right_ff;   req_in    = req_ff;
      res_stat_in = res_stat_ff; res_off_in = res_off_ff;
      rsp_stat_in = rsp_stat_ff; rsp_off_in = rsp_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      hdr_rd_addr  = '0;
      foot_rd_addr = '0;
      hdr_wr       = '0;
      foot_wr      = '0;

      if (rmw_state) begin
         if (!rmw_done) begin
            hdr_rd_addr = rmw_addr;
            phase_in    = 1'b1;
         end else begin
            hdr_wr.en   = phase_ff;
            hdr_wr.addr = rmw_addr;
            hdr_wr.data = rmw_data;
            phase_in    = 1'b0;
            state_in    = rmw_next;
            if (state_ff == S_A_CLR) begin
               res_stat_in = STAT_DONE;
               res_off_in  = ADDR_W'(cur_ff + PTR_W'(DATA_OFFSET));
            end
            if (state_ff == S_E_C && PTR_W'(head_ff) == e_c_ff) begin
               head_in = e_next_ff;
            end
            if (state_ff == S_I_C2 && PTR_W'(head_ff) == ins_w_ff) begin
               head_in = LINK_W'(ins_c_ff);
            end
         end
      end else begin
         case (state_ff)
            // sentinel at the top, one free chunk below it, list of the two
            S_INIT0: begin
               hdr_wr.en    = 1'b1;
               hdr_wr.addr  = PTR_W'(sent);
               hdr_wr.data  = '{prev: '0, next: NIL,
                                size: LINK_W'(CHUNK_OVERHEAD), is_free: 1'b1};
               foot_wr.en   = 1'b1;
               foot_wr.addr = PTR_W'(sent) + PTR_W'(CHUNK_OVERHEAD - 1);
               foot_wr.data = ADDR_W'(sent);
               head_in      = '0;
               tail_in      = sent;
               state_in     = S_INIT1;
            end
            S_INIT1: begin
               hdr_wr.en    = 1'b1;
               hdr_wr.addr  = '0;
               hdr_wr.data  = '{prev: NIL, next: sent, size: sent, is_free: 1'b1};
               foot_wr.en   = 1'b1;
               foot_wr.addr = PTR_W'(sent) - PTR_W'(1);
               foot_wr.data = '0;
               state_in     = S_IDLE;
            end
            S_IDLE: begin
               phase_in = 1'b0;
               if (csr_acc) begin
                  arena_in = csr_clamped;
                  state_in = S_INIT0;
               end else if (req_acc) begin
                  res_off_in = '0;
                  if (req_ch.cmd == CMD_ALLOC) begin
                     cur_in   = PTR_W'(head_ff);
                     steps_in = '0;
                     req_in   = req_ch.req_size;
                     state_in = S_A_CHK;
                  end else if (!req_ch.ptr_valid
                               || req_ch.data_offset < ADDR_W'(DATA_OFFSET)
                               || LINK_W'(off_rel) >= sent) begin
                     res_stat_in = STAT_IGNORED;
                     state_in    = S_DONE;
                  end else begin
                     cur_in   = PTR_W'(off_rel);
                     state_in = S_F_RD;
                  end
               end
            end
            // first-fit walk, one header read per chunk
            S_A_CHK: begin
               if (cur_ff == PTR_W'(tail_ff) || steps_ff == LINK_W'(ARENA_BYTES)) begin
                  res_stat_in = STAT_NOFIT;
                  res_off_in  = '0;
                  state_in    = S_DONE;
               end else begin
                  hdr_rd_addr = cur_ff;
                  state_in    = S_A_EVAL;
               end
            end
            S_A_EVAL: begin
               if (hdr_rd_data.is_free && 17'(hdr_rd_data.size) >= need) begin
                  e_c_in    = cur_ff;
                  e_prev_in = hdr_rd_data.prev;
                  e_next_in = hdr_rd_data.next;
                  h_size_in = hdr_rd_data.size;
                  ret_in    = S_A_POST;
                  state_in  = S_E_P;
               end else begin
                  cur_in   = PTR_W'(hdr_rd_data.next);
                  steps_in = steps_ff + LINK_W'(1);
                  state_in = S_A_CHK;
               end
            end
            S_A_POST: begin
               rest_in  = LINK_W'(rest_w);
               state_in = (rest_w > 17'(CHUNK_OVERHEAD)) ? S_A_LO : S_A_CLR;
            end
            // split: bottom stays free, top is handed out
            S_A_LO: begin
               hdr_wr.en    = 1'b1;
               hdr_wr.addr  = cur_ff;
               hdr_wr.data  = '{prev: NIL, next: NIL, size: rest_ff, is_free: 1'b1};
               foot_wr.en   = 1'b1;
               foot_wr.addr = got - PTR_W'(1);
               foot_wr.data = ADDR_W'(cur_ff);
               state_in     = S_A_HI;
            end
            S_A_HI: begin
               hdr_wr.en    = 1'b1;
               hdr_wr.addr  = got;
               hdr_wr.data  = '{prev: NIL, next: NIL, size: h_size_ff - rest_ff,
                                is_free: 1'b0};
               foot_wr.en   = 1'b1;
               foot_wr.addr = cur_ff + PTR_W'(h_size_ff) - PTR_W'(1);
               foot_wr.data = ADDR_W'(got);
               res_stat_in  = STAT_DONE;
               res_off_in   = ADDR_W'(got + PTR_W'(DATA_OFFSET));
               ins_w_in     = PTR_W'(e_next_ff);
               ins_c_in     = cur_ff;
               ret_in       = S_DONE;
               state_in     = S_I_RD;
            end
            // free: look at both neighbours, merge, push at the head
            S_F_RD: begin
               hdr_rd_addr = cur_ff;
               state_in    = S_F_H;
            end
            S_F_H: begin
               h_size_in    = hdr_rd_data.size;
               lt_in        = cur_ff;
               rt_in        = sum_w;
               right_in     = (sum_w == PTR_W'(sent)) ? PTR_W'(NIL) : sum_w;
               foot_rd_addr = ADDR_W'(cur_ff - PTR_W'(1));
               state_in     = S_F_L;
            end
            S_F_L: begin
               if (cur_ff == '0) begin
                  state_in = S_F_R;
               end else begin
                  e_c_in      = PTR_W'(foot_rd_data);
                  hdr_rd_addr = PTR_W'(foot_rd_data);
                  state_in    = S_F_LEV;
               end
            end
            S_F_LEV: begin
               state_in = S_F_R;
               if (hdr_rd_data.is_free) begin
                  lt_in     = e_c_ff;
                  e_prev_in = hdr_rd_data.prev;
                  e_next_in = hdr_rd_data.next;
                  ret_in    = S_F_R;
                  state_in  = S_E_P;
               end
            end
            S_F_R: begin
               if (right_ff != PTR_W'(NIL)) begin
                  hdr_rd_addr = right_ff;
                  state_in    = S_F_REV;
               end else begin
                  state_in = S_F_MRG;
               end
            end
            S_F_REV: begin
               state_in = S_F_MRG;
               if (hdr_rd_data.is_free) begin
                  rt_in     = right_ff + PTR_W'(hdr_rd_data.size);
                  e_c_in    = right_ff;
                  e_prev_in = hdr_rd_data.prev;
                  e_next_in = hdr_rd_data.next;
                  ret_in    = S_F_MRG;
                  state_in  = S_E_P;
               end
            end
            S_F_MRG: begin
               hdr_wr.en    = 1'b1;
               hdr_wr.addr  = lt_ff;
               hdr_wr.data  = '{prev: NIL, next: NIL, size: LINK_W'(fsz), is_free: 1'b1};
               foot_wr.en   = (rt_ff > lt_ff);
               foot_wr.addr = rt_ff - PTR_W'(1);
               foot_wr.data = ADDR_W'(lt_ff);
               res_stat_in  = STAT_DONE;
               ins_w_in     = PTR_W'(head_ff);
               ins_c_in     = lt_ff;
               ret_in       = S_DONE;
               state_in     = S_I_RD;
            end
            // relink: fetch the predecessor of the insertion point
            S_I_RD: begin
               hdr_rd_addr = ins_w_ff;
               state_in    = S_I_GET;
            end
            S_I_GET: begin
               pp_in    = hdr_rd_data.prev;
               state_in = S_I_C1;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_stat_in  = res_stat_ff;
                  rsp_off_in   = res_off_ff;
                  state_in     = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         ret_ff       <= S_IDLE;
         phase_ff     <= 1'b0;
         arena_ff     <= LINK_W'(ARENA_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         phase_ff     <= phase_in;
         arena_ff     <= arena_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;    tail_ff   <= tail_in;
      steps_ff    <= steps_in;   h_size_ff <= h_size_in; rest_ff  <= rest_in;
      e_prev_ff   <= e_prev_in;  e_next_ff <= e_next_in; pp_ff    <= pp_in;
      cur_ff      <= cur_in;     e_c_ff    <= e_c_in;    ins_w_ff <= ins_w_in;
      ins_c_ff    <= ins_c_in;   lt_ff     <= lt_in;     rt_ff    <= rt_in;
      right_ff    <= right_in;   req_ff    <= req_in;
      res_stat_ff <= res_stat_in; res_off_ff <= res_off_in;
      rsp_stat_ff <= rsp_stat_in; rsp_off_ff <= rsp_off_in;
   end

   // sentinel stays pinned to the arena top once built
   a_tail_at_top: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_INIT0 |-> tail_ff == arena_ff - LINK_W'(CHUNK_OVERHEAD))
      else $error("free list tail off the sentinel");

   a_acc_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("accepted item left no work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside completion");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_A_EVAL |-> steps_ff < LINK_W'(ARENA_BYTES))
      else $error("free list walk overran its bound");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_stat_ff == STAT_DONE || rsp_stat_ff == STAT_NOFIT
                        || rsp_stat_ff == STAT_IGNORED))
      else $error("bad status code");

endmodule

### rtl/core/bta_store.sv
`timescale 1ns / 1ps
module bta_store import bta_pkg::*; (
   input  logic              clock,
   input  logic [PTR_W-1:0]  hdr_rd_addr,
   output hdr_type           hdr_rd_data,
   input  hdr_wr_type        hdr_wr,
   input  logic [ADDR_W-1:0] foot_rd_addr,
   output logic [ADDR_W-1:0] foot_rd_data,
   input  foot_wr_type       foot_wr
);

   hdr_type           hdr_mem [ARENA_BYTES];
   logic [ADDR_W-1:0] foot_mem [ARENA_BYTES];

   hdr_type           hdr_q_ff;
   logic              hdr_oob_ff;
   logic [ADDR_W-1:0] foot_q_ff;

   // writes outside the arena are dropped, reads there answer zero
   always_ff @(posedge clock) begin
      if (hdr_wr.en && hdr_wr.addr < PTR_W'(ARENA_BYTES)) begin
         hdr_mem[hdr_wr.addr[ADDR_W-1:0]] <= hdr_wr.data;
      end
      if (foot_wr.en && foot_wr.addr < PTR_W'(ARENA_BYTES)) begin
         foot_mem[foot_wr.addr[ADDR_W-1:0]] <= foot_wr.data;
      end
      hdr_q_ff   <= hdr_mem[hdr_rd_addr[ADDR_W-1:0]];
      hdr_oob_ff <= (hdr_rd_addr >= PTR_W'(ARENA_BYTES));
      foot_q_ff  <= foot_mem[foot_rd_addr];
   end

   assign hdr_rd_data  = hdr_oob_ff ? '0 : hdr_q_ff;
   assign foot_rd_data = foot_q_ff;

endmodule

### tb/bta_alloc_checker.sv
`timescale 1ns / 1ps
module bta_alloc_checker import bta_pkg::*; (
   input  logic clock,
   input  logic reset,
   bta_req_if   req_mon,
   bta_rsp_if   rsp_mon,
   bta_csr_if   csr_mon,
   output int   errors,
   output int   outstanding
);
   int unsigned link_prev [ARENA_BYTES];
   int unsigned link_next [ARENA_BYTES];
   int unsigned chunk_len [ARENA_BYTES];
   bit          chunk_free[ARENA_BYTES];
   int unsigned foot_start[ARENA_BYTES];
   int unsigned head_chunk, tail_chunk, arena_bytes;

   logic [STAT_W-1:0] want_status[$];
   logic [ADDR_W-1:0] want_offset[$];

   localparam int unsigned NO_LINK = ARENA_BYTES;

   function automatic int unsigned get_prev(int unsigned a);
      return (a < ARENA_BYTES) ? link_prev[a] : 0;
   endfunction
   function automatic int unsigned get_next(int unsigned a);
      return (a < ARENA_BYTES) ? link_next[a] : 0;
   endfunction
   function automatic int unsigned get_len(int unsigned a);
      return (a < ARENA_BYTES) ? chunk_len[a] : 0;
   endfunction
   function automatic bit get_free(int unsigned a);
      return (a < ARENA_BYTES) ? chunk_free[a] : 1'b0;
   endfunction
   function automatic void put_prev(int unsigned a, int unsigned v);
      if (a < ARENA_BYTES) link_prev[a] = v;
   endfunction
   function automatic void put_next(int unsigned a, int unsigned v);
      if (a < ARENA_BYTES) link_next[a] = v;
   endfunction

   function automatic void build_chunk(int unsigned a, int unsigned len, bit fr);
      int unsigned last;
      last = a + len - 1;
      if (a < ARENA_BYTES) begin
         link_prev[a] = NO_LINK;
         link_next[a] = NO_LINK;
         chunk_len[a] = len;
         chunk_free[a] = fr;
      end
      if (len != 0 && last >= a && last < ARENA_BYTES) foot_start[last] = a;
   endfunction

   function automatic void link_before(int unsigned where, int unsigned c);
      int unsigned pp;
      pp = get_prev(where);
      put_prev(c, pp);
      if (pp != NO_LINK) put_next(pp, c);
      put_prev(where, c);
      put_next(c, where);
      if (head_chunk == where) head_chunk = c;
   endfunction

   function automatic int unsigned unlink(int unsigned c);
      int unsigned p, n;
      p = get_prev(c);
      n = get_next(c);
      if (p != NO_LINK) put_next(p, n);
      put_prev(n, p);
      put_prev(c, NO_LINK);
      put_next(c, NO_LINK);
      if (head_chunk == c) head_chunk = n;
      return n;
   endfunction

   function automatic void rebuild_arena();
      int unsigned s;
      s = arena_bytes - CHUNK_OVERHEAD;
      build_chunk(s, CHUNK_OVERHEAD, 1'b1);
      head_chunk = s;
      tail_chunk = s;
      build_chunk(0, s, 1'b1);
      link_before(head_chunk, 0);
   endfunction

   function automatic void predict_alloc(int unsigned want, output logic [STAT_W-1:0] st,
                                         output logic [ADDR_W-1:0] off);
      int unsigned c, steps, where, rest, got, len;
      c = head_chunk;
      steps = 0;
      st = STAT_NOFIT;
      off = '0;
      while (c != tail_chunk && steps < ARENA_BYTES) begin
         len = get_len(c);
         if (get_free(c) && len >= want + CHUNK_OVERHEAD) begin
            where = unlink(c);
            rest = len - want - CHUNK_OVERHEAD;
            got = c;
            if (rest > CHUNK_OVERHEAD) begin
               // keep the bottom in place, hand out the top
               build_chunk(c, rest, 1'b1);
               got = c + rest;
               build_chunk(got, len - rest, 1'b0);
               link_before(where, c);
            end else if (c < ARENA_BYTES) begin
               chunk_free[c] = 1'b0;
            end
            st = STAT_DONE;
            off = ADDR_W'(got + DATA_OFFSET);
            return;
         end
         c = get_next(c);
         steps++;
      end
   endfunction

   function automatic logic [STAT_W-1:0] predict_free(int unsigned off);
      int unsigned c, len, lft, rgt, lo, hi;
      if (off < DATA_OFFSET || off - DATA_OFFSET >= arena_bytes - CHUNK_OVERHEAD)
         return STAT_IGNORED;
      c = off - DATA_OFFSET;
      len = get_len(c);
      lft = (c == 0) ? NO_LINK : ((c - 1 < ARENA_BYTES) ? foot_start[c - 1] : 0);
      rgt = (c + len == arena_bytes - CHUNK_OVERHEAD) ? NO_LINK : c + len;
      lo = c;
      hi = c + len;
      if (lft != NO_LINK && get_free(lft)) begin
         lo = lft;
         void'(unlink(lft));
      end
      if (rgt != NO_LINK && get_free(rgt)) begin
         hi = rgt + get_len(rgt);
         void'(unlink(rgt));
      end
      build_chunk(lo, hi - lo, 1'b1);
      link_before(head_chunk, lo);
      return STAT_DONE;
   endfunction

   always @(posedge clock) begin
      logic [STAT_W-1:0] st;
      logic [ADDR_W-1:0] off;
      int unsigned v;
      if (reset) begin
         arena_bytes = ARENA_BYTES;
         rebuild_arena();
         want_status.delete();
         want_offset.delete();
         errors = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            v = csr_mon.arena_size;
            if (v < MIN_ARENA) v = MIN_ARENA;
            if (v > ARENA_BYTES) v = ARENA_BYTES;
            arena_bytes = v;
            rebuild_arena();
         end
         if (req_mon.valid && req_mon.ready) begin
            off = '0;
            if (req_mon.cmd == CMD_ALLOC) predict_alloc(req_mon.req_size, st, off);
            else if (!req_mon.ptr_valid) st = STAT_IGNORED;
            else st = predict_free(req_mon.data_offset);
            want_status = {want_status, st};
            want_offset = {want_offset, off};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (want_status.size() == 0) begin
               $display("%0t: unexpected result status %0d offset %0d", $time,
                        rsp_mon.status, rsp_mon.result_offset);
               errors++;
            end else begin
               st = want_status.pop_front();
               off = want_offset.pop_front();
               if (rsp_mon.status !== st) begin
                  $display("%0t: status expected %0d got %0d", $time, st, rsp_mon.status);
                  errors++;
               end
               if (rsp_mon.result_offset !== off) begin
                  $display("%0t: result_offset expected %0d got %0d", $time, off,
                           rsp_mon.result_offset);
                  errors++;
               end
            end
         end
      end
      outstanding = want_status.size();
   end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb import bta_pkg::*;;
   logic clock = 1'b0;
   logic reset = 1'b1;

   bta_req_if req_ch();
   bta_rsp_if rsp_ch();
   bta_csr_if csr_ch();

   int errors, outstanding;

   boundary_tag_first_fit_allocator u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   bta_alloc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .errors     (errors),
      .outstanding(outstanding)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // generous cycle limit: long free-list walks plus both sides stalling
   localparam int CYCLE_LIMIT = 3000000;
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   // result side: last accepted item, registered for the sender
   int                rsp_count = 0;
   logic [STAT_W-1:0] last_status;
   logic [ADDR_W-1:0] last_offset;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count   <= rsp_count + 1;
         last_status <= rsp_ch.status;
         last_offset <= rsp_ch.result_offset;
      end
   end

   // result side stalls: bursts of random waits, stretches with none
   initial begin
      int  wait_n;
      bit  stalling;
      rsp_ch.ready = 1'b0;
      stalling = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) stalling = !stalling;
         wait_n = stalling ? $urandom_range(0, 8) : 0;
         if (wait_n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // pointers handed out and not yet given back
   logic [ADDR_W-1:0] live_ptrs[$];
   int unsigned       cur_arena = ARENA_BYTES;
   int                sent = 0, allocs = 0, frees = 0, fits = 0, writes = 0;
   bit                send_gaps = 1'b1;

   // one item, then wait for its result so frees only name live chunks
   task automatic send_item(logic cmd, logic [REQ_W-1:0] sz, logic pv,
                            logic [ADDR_W-1:0] off);
      int gap;
      if ($urandom_range(0, 19) == 0) send_gaps = !send_gaps;
      gap = send_gaps ? $urandom_range(0, 8) : 0;
      repeat (gap) @(posedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.req_size    <= sz;
      req_ch.ptr_valid   <= pv;
      req_ch.data_offset <= off;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      req_ch.valid <= 1'b0;
      sent++;
      while (rsp_count < sent) @(posedge clock);
      if (cmd == CMD_ALLOC) begin
         allocs++;
         if (last_status == STAT_DONE) begin
            live_ptrs = {live_ptrs, last_offset};
            fits++;
         end
      end else begin
         frees++;
      end
   endtask

   task automatic do_alloc(logic [REQ_W-1:0] sz);
      // pointer fields are don't-care on allocate, so toggle them anyway
      send_item(CMD_ALLOC, sz, 1'($urandom), ADDR_W'($urandom));
   endtask

   task automatic free_live(int idx);
      logic [ADDR_W-1:0] p;
      p = live_ptrs[idx];
      live_ptrs.delete(idx);
      send_item(CMD_FREE, REQ_W'($urandom), 1'b1, p);
   endtask

   // free outside the arena: below the data offset or past the sentinel
   task automatic free_outside();
      int unsigned lo;
      lo = cur_arena - CHUNK_OVERHEAD + DATA_OFFSET;
      if ($urandom_range(0, 1) == 0 || lo > ARENA_BYTES - 1)
         send_item(CMD_FREE, REQ_W'($urandom), 1'b1, ADDR_W'($urandom_range(0, DATA_OFFSET - 1)));
      else
         send_item(CMD_FREE, REQ_W'($urandom), 1'b1, ADDR_W'($urandom_range(lo, ARENA_BYTES - 1)));
   endtask

   // arena_size write while idle; the arena rebuild drops every chunk
   task automatic write_arena(logic [LINK_W-1:0] v);
      repeat (4) @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.arena_size <= v;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      repeat (4) @(posedge clock);
      cur_arena = (v < MIN_ARENA) ? MIN_ARENA : ((v > ARENA_BYTES) ? ARENA_BYTES : v);
      live_ptrs.delete();
      writes++;
   endtask

   task automatic random_items(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_item(CMD_FREE, REQ_W'($urandom), 1'b0, ADDR_W'($urandom));
         end else if (pick < 8) begin
            free_outside();
         end else if (pick < 55 || live_ptrs.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) do_alloc(REQ_W'($urandom_range(0, 120)));
            else if (pick < 95) do_alloc(REQ_W'($urandom_range(0, 1500)));
            else do_alloc(REQ_W'($urandom));
         end else begin
            free_live($urandom_range(0, live_ptrs.size() - 1));
         end
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_ALLOC;
      req_ch.req_size    = '0;
      req_ch.ptr_valid   = 1'b0;
      req_ch.data_offset = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.arena_size  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, null and outside frees, merge on both sides
      do_alloc('0);
      do_alloc('1);
      do_alloc(REQ_W'(ARENA_BYTES));
      send_item(CMD_FREE, '0, 1'b0, '1);
      send_item(CMD_FREE, '0, 1'b1, '0);
      send_item(CMD_FREE, '0, 1'b1, '1);
      do_alloc(REQ_W'(100));
      do_alloc(REQ_W'(100));
      do_alloc(REQ_W'(100));
      free_live(1);             // isolated free
      free_live(2);             // merges with its free neighbor
      free_live(1);             // neighbors free on both sides
      free_live(0);
      do_alloc(REQ_W'(ARENA_BYTES - 2 * CHUNK_OVERHEAD)); // takes the whole first chunk
      do_alloc(REQ_W'(0));                                 // nothing left
      free_live(0);

      // smallest arena (a write of zero clamps up): one exact fit, then full
      write_arena('0);
      do_alloc('0);
      do_alloc('0);
      free_live(0);
      free_outside();
      random_items(100);

      write_arena('1);          // clamps down to the largest arena
      random_items(350);
      write_arena(LINK_W'(MIN_ARENA));
      random_items(100);
      write_arena(LINK_W'(300));
      random_items(200);
      write_arena(LINK_W'($urandom_range(MIN_ARENA, ARENA_BYTES)));
      random_items(250);
      write_arena(LINK_W'(ARENA_BYTES));
      random_items(280);

      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d items: %0d allocates (%0d fitted), %0d frees", sent, allocs, fits,
               frees);
      $display("over %0d arena_size writes, down to %0d bytes and up to %0d", writes, MIN_ARENA,
               ARENA_BYTES);
      if (errors == 0 && outstanding == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
